>>> src/cpmd_pkg.sv
// Shared constants and types for the closest-pair minimum distance block.
`timescale 1ns / 1ps
package cpmd_pkg;

  localparam int MAX_POINTS = 64;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int DIST_W     = SQ_W + 1;
  localparam int BEST_W     = DIST_W + 1;
  localparam int FRAC_W     = 8;
  localparam int ROOT_W     = 25;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int STEP_W     = $clog2(ROOT_W);

  localparam logic [BEST_W-1:0] BEST_INIT = '1;

  // one point travelling down the cell chain
  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic                      drop;
    logic                      stored;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [BEST_W-1:0]         best;
  } item_t;

  // end-of-set request from the chain tail to the root unit
  typedef struct packed {
    logic              start;
    logic [DIST_W-1:0] dist_sq;
    logic              no_pair;
    logic              overflow;
  } set_end_t;

endpackage

>>> src/cpmd_cell.sv
// One chain cell: holds one stored point and updates the passing item's minimum.
`timescale 1ns / 1ps
module cpmd_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  cpmd_pkg::item_t item_i,
  output cpmd_pkg::item_t item_o
);
  import cpmd_pkg::*;

  logic                      pt_valid_q, pt_valid_d;
  logic signed [COORD_W-1:0] pt_x_q, pt_x_d, pt_y_q, pt_y_d;

  item_t            a_q, a_d;
  logic             a_hit_q, a_hit_d;
  logic [SQ_W-1:0]  a_sqx_q, a_sqx_d, a_sqy_q, a_sqy_d;
  item_t            b_q, b_d;

  logic                     store_now;
  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [2*DIFF_W-1:0] px, py;
  logic [DIST_W-1:0]        sum_sq;

  // stage A: difference and squares against the stored point
  always_comb begin
    store_now = item_i.valid && !item_i.drop && !item_i.stored && !pt_valid_q;
    dx = $signed({item_i.x[COORD_W-1], item_i.x}) - $signed({pt_x_q[COORD_W-1], pt_x_q});
    dy = $signed({item_i.y[COORD_W-1], item_i.y}) - $signed({pt_y_q[COORD_W-1], pt_y_q});
    px = dx * dx;
    py = dy * dy;
    a_d = item_i;
    a_d.stored = item_i.stored | store_now;
    a_hit_d = pt_valid_q && item_i.valid && !item_i.drop;
    a_sqx_d = px[SQ_W-1:0];
    a_sqy_d = py[SQ_W-1:0];

    pt_valid_d = pt_valid_q;
    pt_x_d = pt_x_q;
    pt_y_d = pt_y_q;
    if (item_i.valid && item_i.last) begin
      pt_valid_d = 1'b0;
    end else if (store_now) begin
      pt_valid_d = 1'b1;
      pt_x_d = item_i.x;
      pt_y_d = item_i.y;
    end
  end

  // stage B: sum and running minimum
  always_comb begin
    sum_sq = {1'b0, a_sqx_q} + {1'b0, a_sqy_q};
    b_d = a_q;
    if (a_hit_q && ({1'b0, sum_sq} < a_q.best)) begin
      b_d.best = {1'b0, sum_sq};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_valid_q <= 1'b0;
      a_q <= '0;
      b_q <= '0;
    end else if (adv_i) begin
      pt_valid_q <= pt_valid_d;
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pt_x_q <= pt_x_d;
      pt_y_q <= pt_y_d;
      a_hit_q <= a_hit_d;
      a_sqx_q <= a_sqx_d;
      a_sqy_q <= a_sqy_d;
    end
  end

  assign item_o = b_q;

  a_hit_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_hit_q |-> a_q.valid && !a_q.drop)
    else $error("cell compare without a live item");

  stored_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_q.valid && b_q.drop |-> !b_q.stored)
    else $error("dropped item marked stored");

  last_clears_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && item_i.valid && item_i.last |=> !pt_valid_q)
    else $error("cell not cleared by last item");

endmodule

>>> src/cpmd_sqrt.sv
// Bit-serial square root in Q8 and the result output register.
`timescale 1ns / 1ps
module cpmd_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cpmd_pkg::set_end_t            req_i,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cpmd_pkg::DIST_W-1:0]   min_dist_sq_o,
  output logic [cpmd_pkg::ROOT_W-1:0]   min_dist_o,
  output logic                          no_pair_o,
  output logic                          overflow_o
);
  import cpmd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [DIST_W-1:0] sq_q, sq_d;
  logic              np_q, np_d, ov_q, ov_d;

  logic              out_valid_q, out_valid_d;
  logic [DIST_W-1:0] o_sq_q, o_sq_d;
  logic [ROOT_W-1:0] o_root_q, o_root_d;
  logic              o_np_q, o_np_d, o_ov_q, o_ov_d;

  logic [REM_W-1:0] rem_n, trial;
  logic             load;

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    rad_d = rad_q;
    rem_d = rem_q;
    root_d = root_q;
    sq_d = sq_q;
    np_d = np_q;
    ov_d = ov_q;
    out_valid_d = out_valid_q;
    o_sq_d = o_sq_q;
    o_root_d = o_root_q;
    o_np_d = o_np_q;
    o_ov_d = o_ov_q;
    load = 1'b0;

    rem_n = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          state_d = S_RUN;
          step_d = STEP_W'(ROOT_W - 1);
          rad_d = RAD_W'({req_i.dist_sq, {(2 * FRAC_W){1'b0}}});
          rem_d = '0;
          root_d = '0;
          sq_d = req_i.dist_sq;
          np_d = req_i.no_pair;
          ov_d = req_i.overflow;
        end
      end
      S_RUN: begin
        rad_d = {rad_q[RAD_W-3:0], 2'b00};
        if (rem_n >= trial) begin
          rem_d = rem_n - trial;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d = rem_n;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        if (step_q == '0) begin
          state_d = S_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load = 1'b1;
          out_valid_d = 1'b1;
          o_sq_d = sq_q;
          o_root_d = root_q;
          o_np_d = np_q;
          o_ov_d = ov_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    rad_q <= rad_d;
    rem_q <= rem_d;
    root_q <= root_d;
    sq_q <= sq_d;
    np_q <= np_d;
    ov_q <= ov_d;
    o_sq_q <= o_sq_d;
    o_root_q <= o_root_d;
    o_np_q <= o_np_d;
    o_ov_q <= o_ov_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign min_dist_sq_o = o_sq_q;
  assign min_dist_o = o_root_q;
  assign no_pair_o = o_np_q;
  assign overflow_o = o_ov_q;

  start_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == S_IDLE)
    else $error("set end while root busy");

  load_goes_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q && state_q == S_IDLE)
    else $error("result load lost");

  no_pair_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_np_q |-> o_sq_q == '0 && o_root_q == '0)
    else $error("no-pair result not zero");

endmodule

>>> src/closest_pair_min_distance.sv
// Top level: closest-pair minimum distance over a streamed set of 2D points.
//
// Input channel (in_valid_i / in_ready_o): one point per item, x_i and y_i
// signed, last_i marks the final point of a set. Within a set a point is
// taken every cycle while the root unit is idle. Up to MAX_POINTS points are
// kept; later points of the set are dropped and reported through overflow_o.
// Each point walks down a chain of MAX_POINTS cells, comparing against
// the point held in each cell and parking in the first empty one. The last
// point clears the cells as it passes.
// Output channel (out_valid_o / out_ready_i): one item per set, after the
// last point has passed the chain and the root unit. When the last point
// leaves the chain a bit-serial root unit runs, and the whole chain (and
// in_ready_o) holds until the result is loaded in the output register.
// A stalled receiver holds the result; the next set keeps streaming until
// its own last point leaves the chain; the chain then holds until that
// set's result is loaded in the output register.
// Reset empties the chain, the running minimum and the output register.
`timescale 1ns / 1ps
module closest_pair_min_distance (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [cpmd_pkg::COORD_W-1:0] x_i,
  input  logic signed [cpmd_pkg::COORD_W-1:0] y_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [cpmd_pkg::DIST_W-1:0]        min_dist_sq_o,
  output logic [cpmd_pkg::ROOT_W-1:0]        min_dist_o,
  output logic                               no_pair_o,
  output logic                               overflow_o
);
  import cpmd_pkg::*;

  item_t    link [MAX_POINTS+1];
  item_t    tail;
  set_end_t req;
  logic     adv, busy;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [BEST_W-1:0] best_q, best_d, best_n;
  logic [1:0]        pairs_q, pairs_d, pairs_n;
  logic              ovf_q, ovf_d, ovf_n;

  assign adv = !busy;
  assign in_ready_o = adv;

  always_comb begin
    link[0].valid = in_valid_i && adv;
    link[0].last = last_i;
    link[0].drop = (cnt_q == CNT_W'(MAX_POINTS));
    link[0].stored = 1'b0;
    link[0].x = x_i;
    link[0].y = y_i;
    link[0].best = BEST_INIT;
  end

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    cpmd_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .item_i(link[g]),
      .item_o(link[g+1])
    );
  end

  assign tail = link[MAX_POINTS];

  always_comb begin
    cnt_d = cnt_q;
    if (link[0].valid) begin
      if (last_i) begin
        cnt_d = '0;
      end else if (!link[0].drop) begin
        cnt_d = cnt_q + 1'b1;
      end
    end

    best_n = (tail.best < best_q) ? tail.best : best_q;
    pairs_n = (tail.stored && pairs_q != 2'd2) ? pairs_q + 2'd1 : pairs_q;
    ovf_n = ovf_q | tail.drop;

    best_d = best_q;
    pairs_d = pairs_q;
    ovf_d = ovf_q;
    req.start = 1'b0;
    req.no_pair = (pairs_n != 2'd2);
    req.dist_sq = req.no_pair ? '0 : best_n[DIST_W-1:0];
    req.overflow = ovf_n;
    if (adv && tail.valid) begin
      if (tail.last) begin
        req.start = 1'b1;
        best_d = BEST_INIT;
        pairs_d = 2'd0;
        ovf_d = 1'b0;
      end else begin
        best_d = best_n;
        pairs_d = pairs_n;
        ovf_d = ovf_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      best_q <= BEST_INIT;
      pairs_q <= 2'd0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      best_q <= best_d;
      pairs_q <= pairs_d;
      ovf_q <= ovf_d;
    end
  end

  cpmd_sqrt u_sqrt (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .min_dist_sq_o(min_dist_sq_o),
    .min_dist_o   (min_dist_o),
    .no_pair_o    (no_pair_o),
    .overflow_o   (overflow_o)
  );

  cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_POINTS))
    else $error("point count past capacity");

  set_end_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && tail.valid && tail.last |=> !in_ready_o)
    else $error("chain kept running during root");

  full_means_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid && tail.drop |-> tail.best == BEST_INIT)
    else $error("dropped point was compared");

endmodule
